>>> rtl/edd_pkg.sv
// ----------------------------------------------------------------------------
// edd_pkg
// Shared types and constants for the edit distance engine.
// ----------------------------------------------------------------------------
package edd_pkg;

  localparam int unsigned DistW  = 6;
  localparam int unsigned SymW   = 8;
  localparam logic [DistW-1:0] DistMax      = 6'd63;
  localparam logic [DistW-1:0] LimitDefault = 6'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PREP,
    S_CELL,
    S_FINISH
  } edd_state_e;

  typedef struct packed {
    logic accept;   // load transfer this cycle
    logic calc;     // lengths settled, set up first row
    logic prep;     // start of a row
    logic cell_en;  // one cell of the current row
    logic finish;   // publish result, clear loader
  } edd_cmd_t;

  typedef struct packed {
    logic pair_closed;  // current item closes a word while the other is already closed
    logic empty;        // one of the words is empty
    logic row_last;     // current cell is the last of its row
    logic col_last;     // current row is the last row
  } edd_sts_t;

endpackage

>>> rtl/edd_ctrl.sv
// ----------------------------------------------------------------------------
// edd_ctrl
// Sequencer: load phase, row by row sweep of the distance table, result.
// ----------------------------------------------------------------------------
module edd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  edd_pkg::edd_sts_t sts_i,
  output edd_pkg::edd_cmd_t cmd_o,
  output logic              busy_o
);

  edd_pkg::edd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= edd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      edd_pkg::S_IDLE: begin
        if (start_i && sts_i.pair_closed) begin
          state_d = edd_pkg::S_CHECK;
        end
      end
      edd_pkg::S_CHECK: begin
        state_d = sts_i.empty ? edd_pkg::S_FINISH : edd_pkg::S_PREP;
      end
      edd_pkg::S_PREP: begin
        state_d = edd_pkg::S_CELL;
      end
      edd_pkg::S_CELL: begin
        if (sts_i.row_last) begin
          state_d = sts_i.col_last ? edd_pkg::S_FINISH : edd_pkg::S_PREP;
        end
      end
      edd_pkg::S_FINISH: begin
        state_d = edd_pkg::S_IDLE;
      end
      default: begin
        state_d = edd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    busy_o       = 1'b1;
    unique case (state_q)
      edd_pkg::S_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      edd_pkg::S_CHECK:  cmd_o.calc    = 1'b1;
      edd_pkg::S_PREP:   cmd_o.prep    = 1'b1;
      edd_pkg::S_CELL:   cmd_o.cell_en = 1'b1;
      edd_pkg::S_FINISH: cmd_o.finish  = 1'b1;
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/edd_datapath.sv
// ----------------------------------------------------------------------------
// edd_datapath
// Word stores, rolling row memory, cell update and result registers.
// ----------------------------------------------------------------------------
module edd_datapath #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  edd_pkg::edd_cmd_t           cmd_i,
  output edd_pkg::edd_sts_t           sts_o,
  input  logic                        word_sel_i,
  input  logic [edd_pkg::SymW-1:0]    symbol_i,
  input  logic                        has_symbol_i,
  input  logic                        last_i,
  input  logic                        cfg_we_i,
  input  logic [edd_pkg::DistW-1:0]   cfg_data_i,
  output logic                        result_valid_o,
  output logic [edd_pkg::DistW-1:0]   distance_o,
  output logic                        is_close_o,
  output logic                        too_long_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = (LW > edd_pkg::DistW) ? LW : edd_pkg::DistW;

  logic [edd_pkg::SymW-1:0] first_mem  [MAX_LEN];
  logic [edd_pkg::SymW-1:0] second_mem [MAX_LEN];
  logic [LW-1:0]            row_mem    [MAX_LEN+1];

  logic [LW-1:0] len1_q, len2_q;
  logic          done1_q, done2_q, ovf_q;
  logic [edd_pkg::DistW-1:0] limit_q;

  logic [LW-1:0] i_q, j_q, left_q, diag_q;
  logic [edd_pkg::SymW-1:0] frd_q, srd_q;
  logic [LW-1:0] row_rd_q;

  logic applies, closes_other, wr1, wr2, full1, full2;
  logic rd_en;
  logic [LW-1:0] row_raddr;
  logic [AW-1:0] s_raddr;
  logic [LW-1:0] up;
  logic [LW:0]   c_up, c_left, c_diag, c_min;
  logic [LW-1:0] dist_full;
  logic [CW-1:0] dist_ext;

  // loader
  assign applies      = word_sel_i ? !done2_q : !done1_q;
  assign closes_other = word_sel_i ? done1_q : done2_q;
  assign full1        = (len1_q >= LW'(MAX_LEN));
  assign full2        = (len2_q >= LW'(MAX_LEN));
  assign wr1 = cmd_i.accept && !word_sel_i && !done1_q && has_symbol_i && !full1;
  assign wr2 = cmd_i.accept &&  word_sel_i && !done2_q && has_symbol_i && !full2;

  assign sts_o.pair_closed = applies && last_i && closes_other;
  assign sts_o.empty       = (len1_q == '0) || (len2_q == '0);
  assign sts_o.row_last    = (j_q == len2_q);
  assign sts_o.col_last    = (i_q == len1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len1_q  <= '0;
      len2_q  <= '0;
      done1_q <= 1'b0;
      done2_q <= 1'b0;
      ovf_q   <= 1'b0;
      limit_q <= edd_pkg::LimitDefault;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.finish) begin
        len1_q  <= '0;
        len2_q  <= '0;
        done1_q <= 1'b0;
        done2_q <= 1'b0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.accept && applies) begin
        if (wr1) len1_q <= len1_q + 1'b1;
        if (wr2) len2_q <= len2_q + 1'b1;
        if (has_symbol_i && (word_sel_i ? full2 : full1)) begin
          ovf_q <= 1'b1;
        end
        if (last_i) begin
          if (word_sel_i) done2_q <= 1'b1;
          else            done1_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr1) first_mem[len1_q[AW-1:0]] <= symbol_i;
    if (wr2) second_mem[len2_q[AW-1:0]] <= symbol_i;
  end

  // memory reads
  assign rd_en     = cmd_i.prep || (cmd_i.cell_en && !sts_o.row_last);
  assign row_raddr = cmd_i.prep ? LW'(1) : j_q + 1'b1;
  assign s_raddr   = cmd_i.prep ? '0 : j_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      frd_q <= first_mem[AW'(i_q - 1'b1)];
    end
    if (rd_en) begin
      srd_q    <= second_mem[s_raddr];
      row_rd_q <= row_mem[row_raddr];
    end
    if (cmd_i.cell_en) begin
      row_mem[j_q] <= c_min[LW-1:0];
    end
  end

  // cell update
  assign up     = (i_q == LW'(1)) ? j_q : row_rd_q;
  assign c_up   = {1'b0, up} + 1'b1;
  assign c_left = {1'b0, left_q} + 1'b1;
  assign c_diag = {1'b0, diag_q} + {{LW{1'b0}}, (frd_q != srd_q)};

  always_comb begin
    c_min = (c_up < c_left) ? c_up : c_left;
    if (c_diag < c_min) c_min = c_diag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else begin
      if (cmd_i.calc) begin
        i_q <= LW'(1);
      end else if (cmd_i.cell_en && sts_o.row_last && !sts_o.col_last) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.prep) begin
        j_q <= LW'(1);
      end else if (cmd_i.cell_en && !sts_o.row_last) begin
        j_q <= j_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      left_q <= i_q;
      diag_q <= i_q - 1'b1;
    end else if (cmd_i.cell_en) begin
      left_q <= c_min[LW-1:0];
      diag_q <= up;
    end
  end

  // result
  always_comb begin
    priority if (len1_q == '0) dist_full = len2_q;
    else if (len2_q == '0)      dist_full = len1_q;
    else                        dist_full = left_q;
  end
  assign dist_ext = CW'(dist_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      distance_o <= (dist_ext > CW'(edd_pkg::DistMax)) ? edd_pkg::DistMax
                                                       : dist_ext[edd_pkg::DistW-1:0];
      is_close_o <= (dist_ext <= CW'(limit_q));
      too_long_o <= ovf_q;
    end
  end

endmodule

>>> rtl/edit_distance_engine_top.sv
// ----------------------------------------------------------------------------
// edit_distance_engine_top
// Levenshtein distance between two loaded words, one result per word pair.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  load     | start_i, busy_o           | word_sel_i symbol_i has_symbol_i last_i
//  config   | cfg_valid_i, cfg_ready_o  | cfg_data_i (close_limit)
//  result   | result_valid_o (strobe)   | distance_o is_close_o too_long_o
//
//  The load transfer closing the pair starts the sweep: busy through a check
//  step, then per row a prep step and one cell of the rolling row per cycle
//  through the row memory port, then a finish step (check and finish only
//  with an empty word); the result strobe follows as busy drops. After
//  reset the block is ready at once; results cannot be stalled.
// ----------------------------------------------------------------------------
module edit_distance_engine_top #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       word_sel_i,
  input  logic [7:0] symbol_i,
  input  logic       has_symbol_i,
  input  logic       last_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i,
  output logic       result_valid_o,
  output logic [5:0] distance_o,
  output logic       is_close_o,
  output logic       too_long_o
);

  edd_pkg::edd_cmd_t cmd;
  edd_pkg::edd_sts_t sts;

  assign cfg_ready_o = !busy_o;

  edd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  edd_datapath #(
    .MAX_LEN(MAX_LEN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .word_sel_i    (word_sel_i),
    .symbol_i      (symbol_i),
    .has_symbol_i  (has_symbol_i),
    .last_i        (last_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .distance_o    (distance_o),
    .is_close_o    (is_close_o),
    .too_long_o    (too_long_o)
  );

endmodule

>>> rtl/edd_checker.sv
// ----------------------------------------------------------------------------
// edd_checker
// Port-level checks on the edit distance engine, bound to the top level.
// ----------------------------------------------------------------------------
module edd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       result_valid_o,
  input logic [5:0] distance_o,
  input logic       is_close_o
);

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobe while busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy without a load transfer");

  a_busy_ends_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o)
    else $error("sweep ended without a result");

  a_zero_is_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && distance_o == 6'd0) |-> is_close_o)
    else $error("zero distance not flagged close");

endmodule

bind edit_distance_engine_top edd_checker u_edd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .result_valid_o(result_valid_o),
  .distance_o    (distance_o),
  .is_close_o    (is_close_o)
);

>>> dv/tb_edit_distance_engine_top.sv
// ----------------------------------------------------------------------------
// tb_edit_distance_engine_top
// Self-checking bench for the edit distance engine: directed word pairs cover
// empty words, extreme symbols, items for a closed word and the limit
// extremes; then randomised and mutated word pairs, with overlong words, run
// under three idle regimes. A local Levenshtein predictor with its own
// loader state provides the expected distance, close flag and overflow flag.
// ----------------------------------------------------------------------------
module tb_edit_distance_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SymW  = edd_pkg::SymW;
  localparam int unsigned DistW = edd_pkg::DistW;
  localparam logic [DistW-1:0] DistMax      = edd_pkg::DistMax;
  localparam logic [DistW-1:0] LimitDefault = edd_pkg::LimitDefault;

  localparam int unsigned MaxLen      = 32;
  localparam int unsigned LongestWord = 40;
  localparam longint unsigned CycleLimit = 10_000_000;
  localparam logic WordFirst  = 1'b0;
  localparam logic WordSecond = 1'b1;

  typedef struct packed {
    logic            word_sel;
    logic [SymW-1:0] symbol;
    logic            has_symbol;
    logic            last;
  } load_item_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             is_close;
    logic             too_long;
  } distance_record_t;

  typedef logic [SymW-1:0] symbol_queue_t[$];
  typedef load_item_t item_queue_t[$];
  typedef enum {EDIT_SUBST, EDIT_INSERT, EDIT_DELETE} edit_kind_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic             word_sel_i = 1'b0;
  logic [SymW-1:0]  symbol_i = '0;
  logic             has_symbol_i = 1'b0;
  logic             last_i = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [DistW-1:0] cfg_data_i = '0;
  logic             result_valid_o;
  logic [DistW-1:0] distance_o;
  logic             is_close_o;
  logic             too_long_o;

  // predictor state
  logic [SymW-1:0]  word_store[2][MaxLen];
  int unsigned      word_len[2];
  bit               word_closed[2];
  bit               length_overflow;
  logic [DistW-1:0] close_limit_q = LimitDefault;

  distance_record_t expected_distances[$];
  distance_record_t head_expected;
  int unsigned      error_count = 0;
  int unsigned      items_sent = 0;
  int unsigned      sender_idle_pct = 0;
  longint unsigned  cycle_count = 0;

  edit_distance_engine_top #(
    .MAX_LEN(MaxLen)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .word_sel_i    (word_sel_i),
    .symbol_i      (symbol_i),
    .has_symbol_i  (has_symbol_i),
    .last_i        (last_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .distance_o    (distance_o),
    .is_close_o    (is_close_o),
    .too_long_o    (too_long_o)
  );

  always begin
    #10ns clk_i = 1'b1;
    #10ns clk_i = 1'b0;
  end

  function automatic int unsigned pair_distance();
    int unsigned row[MaxLen+1];
    int unsigned diag, up, cost, best, i, j;
    for (j = 0; j <= word_len[1]; j++) row[j] = j;
    for (i = 1; i <= word_len[0]; i++) begin
      diag   = row[0];
      row[0] = i;
      for (j = 1; j <= word_len[1]; j++) begin
        up   = row[j];
        cost = (word_store[0][i-1] == word_store[1][j-1]) ? 0 : 1;
        best = diag + cost;
        if (up + 1 < best) best = up + 1;
        if (row[j-1] + 1 < best) best = row[j-1] + 1;
        diag   = up;
        row[j] = best;
      end
    end
    return row[word_len[1]];
  endfunction

  function automatic void model_accept(input load_item_t it);
    int unsigned sel, edit_dist;
    distance_record_t rec;
    sel = {31'b0, it.word_sel};
    if (word_closed[sel]) return;
    if (it.has_symbol) begin
      if (word_len[sel] < MaxLen) begin
        word_store[sel][word_len[sel]] = it.symbol;
        word_len[sel]++;
      end else begin
        length_overflow = 1'b1;
      end
    end
    if (it.last) word_closed[sel] = 1'b1;
    if (word_closed[0] && word_closed[1]) begin
      edit_dist = pair_distance();
      rec.distance = (edit_dist > 32'(DistMax)) ? DistMax : edit_dist[DistW-1:0];
      rec.is_close = (edit_dist <= 32'(close_limit_q));
      rec.too_long = length_overflow;
      expected_distances.push_back(rec);
      word_len[0]     = 0;
      word_len[1]     = 0;
      word_closed[0]  = 1'b0;
      word_closed[1]  = 1'b0;
      length_overflow = 1'b0;
    end
  endfunction

  function automatic load_item_t make_item(input logic sel, input logic [SymW-1:0] sym,
                                           input logic has, input logic fin);
    load_item_t it;
    it.word_sel   = sel;
    it.symbol     = sym;
    it.has_symbol = has;
    it.last       = fin;
    return it;
  endfunction

  // mostly a four-letter alphabet so that matches are common
  function automatic logic [SymW-1:0] random_symbol();
    if ($urandom_range(9) < 7) return SymW'(8'h61 + $urandom_range(3));
    return SymW'($urandom_range(255));
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(6);
    if (r < 94) return $urandom_range(20, 7);
    if (r < 98) return $urandom_range(MaxLen, 21);
    return $urandom_range(LongestWord, MaxLen + 1);
  endfunction

  function automatic symbol_queue_t random_word(input int unsigned len);
    symbol_queue_t w;
    repeat (len) w.push_back(random_symbol());
    return w;
  endfunction

  function automatic symbol_queue_t mutate_word(input symbol_queue_t src);
    symbol_queue_t w;
    edit_kind_e kind;
    w = src;
    repeat ($urandom_range(3)) begin
      kind = edit_kind_e'($urandom_range(2));
      case (kind)
        EDIT_SUBST: begin
          if (w.size() != 0) w[$urandom_range(w.size() - 1)] = random_symbol();
        end
        EDIT_INSERT: begin
          if (w.size() < LongestWord) w.insert($urandom_range(w.size()), random_symbol());
        end
        default: begin
          if (w.size() != 0) w.delete($urandom_range(w.size() - 1));
        end
      endcase
    end
    return w;
  endfunction

  // symbol items with the odd no-op mixed in; closed on the final symbol or by a bare marker
  function automatic item_queue_t word_items(input logic sel, input symbol_queue_t w);
    item_queue_t q;
    load_item_t it;
    int unsigned k;
    for (k = 0; k < w.size(); k++) begin
      if ($urandom_range(9) == 0) q.push_back(make_item(sel, random_symbol(), 1'b0, 1'b0));
      q.push_back(make_item(sel, w[k], 1'b1, 1'b0));
    end
    if (w.size() != 0 && $urandom_range(1)) begin
      it = q.pop_back();
      it.last = 1'b1;
      q.push_back(it);
    end else begin
      q.push_back(make_item(sel, SymW'($urandom_range(255)), 1'b0, 1'b1));
    end
    return q;
  endfunction

  task automatic send_item(input load_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    @(negedge clk_i);
    start_i      = 1'b1;
    word_sel_i   = it.word_sel;
    symbol_i     = it.symbol;
    has_symbol_i = it.has_symbol;
    last_i       = it.last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
    model_accept(it);
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_distances.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_close_limit(input logic [DistW-1:0] value);
    wait_results_drained();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    close_limit_q = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // when noisy, items for the closed word are slipped in while the other word is still open
  task automatic send_word_pair(input symbol_queue_t word_a, input symbol_queue_t word_b,
                                input bit noisy);
    item_queue_t qa, qb;
    load_item_t it;
    bit pick_b;
    qa = word_items(WordFirst, word_a);
    qb = word_items(WordSecond, word_b);
    while (qa.size() + qb.size() != 0) begin
      if (qa.size() == 0) pick_b = 1'b1;
      else if (qb.size() == 0) pick_b = 1'b0;
      else pick_b = 1'($urandom_range(1));
      if (noisy && (qa.size() == 0 || qb.size() == 0) && $urandom_range(3) == 0)
        send_item(make_item((qa.size() == 0) ? WordFirst : WordSecond,
                            SymW'($urandom_range(255)),
                            1'($urandom_range(1)), 1'($urandom_range(1))));
      it = pick_b ? qb.pop_front() : qa.pop_front();
      send_item(it);
    end
  endtask

  task automatic send_random_pair();
    symbol_queue_t wa, wb;
    wa = random_word(pick_length());
    if ($urandom_range(1)) wb = mutate_word(wa);
    else wb = random_word(pick_length());
    if ($urandom_range(1)) send_word_pair(wa, wb, $urandom_range(4) == 0);
    else send_word_pair(wb, wa, $urandom_range(4) == 0);
  endtask

  task automatic test_directed_cases();
    sender_idle_pct = 0;
    // two empty words
    send_item(make_item(WordFirst, 8'h00, 1'b0, 1'b1));
    send_item(make_item(WordSecond, 8'hFF, 1'b0, 1'b1));
    // extreme symbols, closed on the final symbol
    send_item(make_item(WordFirst, 8'h00, 1'b1, 1'b0));
    send_item(make_item(WordFirst, 8'hFF, 1'b1, 1'b1));
    send_item(make_item(WordSecond, 8'hFF, 1'b1, 1'b1));
    // second word closes first, then an item for it is ignored
    send_item(make_item(WordSecond, 8'h61, 1'b1, 1'b1));
    send_item(make_item(WordSecond, 8'h62, 1'b1, 1'b1));
    send_item(make_item(WordFirst, 8'h00, 1'b0, 1'b0));
    send_item(make_item(WordFirst, 8'h78, 1'b1, 1'b1));
    // empty against three symbols, beyond the default limit
    send_item(make_item(WordFirst, 8'h00, 1'b0, 1'b1));
    send_item(make_item(WordSecond, 8'h61, 1'b1, 1'b0));
    send_item(make_item(WordSecond, 8'h62, 1'b1, 1'b0));
    send_item(make_item(WordSecond, 8'h63, 1'b1, 1'b0));
    send_item(make_item(WordSecond, 8'h00, 1'b0, 1'b1));
    // identical words, interleaved
    send_item(make_item(WordFirst, 8'h61, 1'b1, 1'b0));
    send_item(make_item(WordSecond, 8'h61, 1'b1, 1'b0));
    send_item(make_item(WordFirst, 8'h62, 1'b1, 1'b1));
    send_item(make_item(WordSecond, 8'h62, 1'b1, 1'b1));
    wait_results_drained();
  endtask

  task automatic test_close_limit_extremes();
    symbol_queue_t all_a, all_b, none;
    all_a = {};
    all_b = {};
    none  = {};
    repeat (MaxLen) begin
      all_a.push_back(8'h61);
      all_b.push_back(8'h62);
    end
    write_close_limit(6'd0);
    send_word_pair('{8'h61, 8'h62}, '{8'h61, 8'h62}, 1'b0);
    send_word_pair('{8'h61}, '{8'h62}, 1'b0);
    write_close_limit(6'd32);
    send_word_pair(all_a, none, 1'b0);
    send_word_pair(all_a, all_b, 1'b0);
    write_close_limit(6'd31);
    send_word_pair(none, all_b, 1'b0);
    send_word_pair(all_b, all_b, 1'b0);
  endtask

  task automatic test_long_words();
    send_word_pair(random_word($urandom_range(LongestWord, MaxLen + 1)),
                   random_word(MaxLen), 1'b0);
    send_word_pair(random_word(MaxLen),
                   random_word($urandom_range(LongestWord, MaxLen + 1)), 1'b1);
    send_word_pair(random_word(LongestWord), random_word(LongestWord), 1'b0);
    send_word_pair(random_word(MaxLen), random_word(0), 1'b0);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned target,
                                     input logic [DistW-1:0] limit);
    int unsigned first_count;
    write_close_limit(limit);
    sender_idle_pct = idle_pct;
    first_count = items_sent;
    while (items_sent - first_count < target) begin
      send_random_pair();
      if ($urandom_range(24) == 0) wait_results_drained();
    end
    wait_results_drained();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_distances.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual distance %0d close %0b long %0b",
                 $time, distance_o, is_close_o, too_long_o);
      end else begin
        head_expected = expected_distances.pop_front();
        if (distance_o !== head_expected.distance) begin
          error_count++;
          $display("%0t: distance mismatch: expected %0d, actual %0d",
                   $time, head_expected.distance, distance_o);
        end
        if (is_close_o !== head_expected.is_close) begin
          error_count++;
          $display("%0t: is_close mismatch: expected %0b, actual %0b",
                   $time, head_expected.is_close, is_close_o);
        end
        if (too_long_o !== head_expected.too_long) begin
          error_count++;
          $display("%0t: too_long mismatch: expected %0b, actual %0b",
                   $time, head_expected.too_long, too_long_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_distances.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    word_len[0]     = 0;
    word_len[1]     = 0;
    word_closed[0]  = 1'b0;
    word_closed[1]  = 1'b0;
    length_overflow = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_close_limit_extremes();
    test_long_words();
    test_random_traffic(15, 375, DistW'($urandom_range(30, 1)));
    test_random_traffic(77, 375, LimitDefault);
    test_random_traffic(0, 375, DistW'($urandom_range(32)));

    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && expected_distances.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
